// ===== hw/rtl/smoothed_value_noise_octaves_assert.svh =====
// Assertion macros shared by the checker of the noise block.
// Depends on nothing; included by smvn_checker.sv.
`ifndef SMOOTHED_VALUE_NOISE_OCTAVES_ASSERT_SVH
`define SMOOTHED_VALUE_NOISE_OCTAVES_ASSERT_SVH

// Same-cycle implication.
`define SMVN_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("smvn: same-cycle check failed");

// Next-cycle implication.
`define SMVN_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("smvn: next-cycle check failed");

`endif

// ===== hw/rtl/smvn_pkg.sv =====
// Types and constants of the smoothed value noise block.
// Used by smvn_ctrl, smvn_datapath and the top level; depends on nothing.
package smvn_pkg;

    localparam int MA_W   = 36;
    localparam int MB_W   = 33;
    localparam int MP_W   = MA_W + MB_W;
    localparam int CRN_W  = 36;
    localparam int CRV_W  = 29;
    localparam int VAL_W  = 24;
    localparam int AMP_W  = 32;
    localparam int SUM_W  = 44;
    localparam int FR_W   = 18;
    localparam int ACC_W  = 66;
    localparam int OCT_CMD_W = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [31:0] HASH_YMUL = 32'd57;
    localparam logic [31:0] HASH_C2   = 32'd15731;
    localparam logic [31:0] HASH_C3   = 32'd789221;
    localparam logic [31:0] HASH_C4   = 32'd1376312589;
    localparam logic [31:0] HASH_MASK = 32'h7fffffff;
    localparam logic [31:0] LAT_ONE   = 32'h40000000;
    localparam logic [AMP_W-1:0] AMP_ONE = AMP_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERSISTENCE = 3'd0,
        CFG_BASE_FREQ   = 3'd1,
        CFG_OUTPUT_GAIN = 3'd2,
        CFG_OCT_COUNT   = 3'd3,
        CFG_SEED_OFFSET = 3'd4
    } cfg_idx_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_MUL_SX,
        OP_SCALE_X,
        OP_SCALE_Y,
        OP_HASH_SQ,
        OP_HASH_POLY,
        OP_HASH_MUL,
        OP_HASH_ACC,
        OP_CURVE_SQ,
        OP_CURVE_CUBE,
        OP_CURVE_STORE,
        OP_BLEND_0,
        OP_BLEND_1,
        OP_BLEND_2,
        OP_TERM,
        OP_SUM_AMP,
        OP_AMP,
        OP_FIN_LO,
        OP_FIN_HI,
        OP_FIN_OUT
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [1:0]           sel;
        logic [3:0]           pt;
        logic [OCT_CMD_W-1:0] oct;
    } cmd_t;

endpackage

// ===== hw/rtl/smvn_ctrl.sv =====
// Sequencer of the smoothed value noise block: octave, lattice point and step counters.
// Depends on smvn_pkg; drives smvn_datapath through smvn_pkg::cmd_t.
module smvn_ctrl #(
    parameter int MAX_OCTAVES = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [3:0]        octave_count,
    output logic              busy,
    output logic              done,
    output smvn_pkg::cmd_t    cmd
);

    localparam int OCT_W = $clog2(MAX_OCTAVES + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_SX, S_SY, S_SCL,
        S_H0, S_H1, S_H2, S_H3,
        S_C0, S_C1, S_C2,
        S_B0, S_B1, S_B2,
        S_T0, S_T1, S_T2,
        S_F0, S_F1, S_F2
    } state_t;

    state_t             state_reg;
    logic [OCT_W-1:0]   k_reg;
    logic [OCT_W-1:0]   cnt_reg;
    logic [3:0]         pt_reg;
    logic [1:0]         sel_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [OCT_W-1:0]   cnt_next;

    always_comb
    begin
        if (32'(octave_count) > MAX_OCTAVES)
        begin
            cnt_next = OCT_W'(MAX_OCTAVES);
        end
        else
        begin
            cnt_next = OCT_W'(octave_count);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            cnt_reg   <= '0;
            pt_reg    <= '0;
            sel_reg   <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        busy_reg <= 1'b1;
                        cnt_reg  <= cnt_next;
                        k_reg    <= '0;
                        state_reg <= (cnt_next == '0) ? S_F0 : S_SX;
                    end
                end
                S_SX:  state_reg <= S_SY;
                S_SY:  state_reg <= S_SCL;
                S_SCL:
                begin
                    pt_reg    <= '0;
                    state_reg <= S_H0;
                end
                S_H0:  state_reg <= S_H1;
                S_H1:  state_reg <= S_H2;
                S_H2:  state_reg <= S_H3;
                S_H3:
                begin
                    if (pt_reg == 4'hf)
                    begin
                        sel_reg   <= '0;
                        state_reg <= S_C0;
                    end
                    else
                    begin
                        pt_reg    <= pt_reg + 4'd1;
                        state_reg <= S_H0;
                    end
                end
                S_C0:  state_reg <= S_C1;
                S_C1:  state_reg <= S_C2;
                S_C2:
                begin
                    sel_reg <= sel_reg + 2'd1;
                    state_reg <= (sel_reg == 2'd3) ? S_B0 : S_C0;
                end
                S_B0:  state_reg <= S_B1;
                S_B1:  state_reg <= S_B2;
                S_B2:
                begin
                    sel_reg <= (sel_reg == 2'd2) ? 2'd0 : sel_reg + 2'd1;
                    state_reg <= (sel_reg == 2'd2) ? S_T0 : S_B0;
                end
                S_T0:  state_reg <= S_T1;
                S_T1:  state_reg <= S_T2;
                S_T2:
                begin
                    k_reg <= k_reg + OCT_W'(1);
                    state_reg <= ((k_reg + OCT_W'(1)) == cnt_reg) ? S_F0 : S_SX;
                end
                S_F0:  state_reg <= S_F1;
                S_F1:  state_reg <= S_F2;
                S_F2:
                begin
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        cmd.sel = sel_reg;
        cmd.pt  = pt_reg;
        cmd.oct = smvn_pkg::OCT_CMD_W'(k_reg);
        unique case (state_reg)
            S_SX:    cmd.op = smvn_pkg::OP_MUL_SX;
            S_SY:    cmd.op = smvn_pkg::OP_SCALE_X;
            S_SCL:   cmd.op = smvn_pkg::OP_SCALE_Y;
            S_H0:    cmd.op = smvn_pkg::OP_HASH_SQ;
            S_H1:    cmd.op = smvn_pkg::OP_HASH_POLY;
            S_H2:    cmd.op = smvn_pkg::OP_HASH_MUL;
            S_H3:    cmd.op = smvn_pkg::OP_HASH_ACC;
            S_C0:    cmd.op = smvn_pkg::OP_CURVE_SQ;
            S_C1:    cmd.op = smvn_pkg::OP_CURVE_CUBE;
            S_C2:    cmd.op = smvn_pkg::OP_CURVE_STORE;
            S_B0:    cmd.op = smvn_pkg::OP_BLEND_0;
            S_B1:    cmd.op = smvn_pkg::OP_BLEND_1;
            S_B2:    cmd.op = smvn_pkg::OP_BLEND_2;
            S_T0:    cmd.op = smvn_pkg::OP_TERM;
            S_T1:    cmd.op = smvn_pkg::OP_SUM_AMP;
            S_T2:    cmd.op = smvn_pkg::OP_AMP;
            S_F0:    cmd.op = smvn_pkg::OP_FIN_LO;
            S_F1:    cmd.op = smvn_pkg::OP_FIN_HI;
            S_F2:    cmd.op = smvn_pkg::OP_FIN_OUT;
            default: cmd.op = smvn_pkg::OP_NONE;
        endcase
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// ===== hw/rtl/smvn_datapath.sv =====
// Datapath of the smoothed value noise block: one shared multiplier and working registers.
// Depends on smvn_pkg; steered by smvn_ctrl through smvn_pkg::cmd_t.
module smvn_datapath (
    input  logic                clk,
    input  smvn_pkg::cmd_t      cmd,
    input  logic                capture,
    input  logic signed [31:0]  coord_x,
    input  logic signed [31:0]  coord_y,
    input  logic [16:0]         persistence,
    input  logic [23:0]         base_frequency,
    input  logic [23:0]         output_gain,
    input  logic [30:0]         seed_offset,
    output logic signed [31:0]  height
);

    localparam int MA_W  = smvn_pkg::MA_W;
    localparam int MB_W  = smvn_pkg::MB_W;
    localparam int MP_W  = smvn_pkg::MP_W;
    localparam int CRN_W = smvn_pkg::CRN_W;
    localparam int CRV_W = smvn_pkg::CRV_W;
    localparam int VAL_W = smvn_pkg::VAL_W;
    localparam int AMP_W = smvn_pkg::AMP_W;
    localparam int SUM_W = smvn_pkg::SUM_W;
    localparam int FR_W  = smvn_pkg::FR_W;
    localparam int ACC_W = smvn_pkg::ACC_W;

    logic signed [31:0]       cx_reg, cy_reg;
    logic [31:0]              xi_reg, yi_reg;
    logic signed [FR_W-1:0]   xf_reg, yf_reg;
    logic [31:0]              n_reg, m_reg;
    logic signed [CRN_W-1:0]  c00_reg, c10_reg, c01_reg, c11_reg;
    logic signed [CRV_W-1:0]  wx0_reg, wx1_reg, wy0_reg, wy1_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [CRN_W-1:0]  v1_reg, v2_reg;
    logic signed [VAL_W-1:0]  val_reg;
    logic [AMP_W-1:0]         amp_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic [55:0]              lo_reg;
    logic signed [MP_W-1:0]   prod_reg;
    logic signed [31:0]       height_reg;

    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic                     mul_en;

    // coordinate scaling
    logic signed [55:0]       sp;
    logic [55:0]              smag;
    logic [4:0]               shamt;
    logic [55:0]              ssh;
    logic signed [57:0]       sv;
    logic [57:0]              vm;
    logic [31:0]              s_int;
    logic signed [FR_W-1:0]   s_frac;

    // lattice hash
    logic [31:0]              lat_x, lat_y, n0, hn, poly, t_hash;
    logic signed [31:0]       lval;
    logic signed [CRN_W-1:0]  lval_ext;
    logic signed [CRN_W-1:0]  add00, add10, add01, add11;

    // curve and blend
    logic signed [18:0]       crv_a;
    logic signed [20:0]       fac;
    logic signed [CRN_W-1:0]  bl_p, bl_q;
    logic signed [CRV_W-1:0]  bl_w0, bl_w1;
    logic signed [ACC_W-1:0]  bsum;

    // final scaling
    logic                     sneg;
    logic [SUM_W-1:0]         mag;
    logic [34:0]              hi;
    logic [41:0]              q;
    logic signed [31:0]       h_next;

    function automatic logic signed [CRN_W-1:0] corner_add(
        input logic [3:0] pt,
        input logic       ca,
        input logic       cb,
        input logic signed [CRN_W-1:0] v
    );
        logic [1:0] i;
        logic [1:0] j;
        logic       in_x;
        logic       in_y;
        logic       mid_x;
        logic       mid_y;
        i = pt[1:0];
        j = pt[3:2];
        in_x  = ca ? (i != 2'd0) : (i != 2'd3);
        in_y  = cb ? (j != 2'd0) : (j != 2'd3);
        mid_x = (i == {1'b0, ca} + 2'd1);
        mid_y = (j == {1'b0, cb} + 2'd1);
        if (!(in_x && in_y))
        begin
            return '0;
        end
        else if (mid_x && mid_y)
        begin
            return v <<< 2;
        end
        else if (mid_x || mid_y)
        begin
            return v <<< 1;
        end
        else
        begin
            return v;
        end
    endfunction

    always_comb
    begin
        sp     = prod_reg[55:0];
        smag   = sp[55] ? 56'(-sp) : 56'(sp);
        shamt  = 5'd16 - {1'b0, cmd.oct};
        ssh    = smag >> shamt;
        sv     = (sp[55] ? -$signed({2'b00, ssh}) : $signed({2'b00, ssh}))
               + $signed({11'b0, seed_offset, 16'b0});
        vm     = sv[57] ? 58'(-sv) : 58'(sv);
        s_int  = sv[57] ? -vm[47:16] : vm[47:16];
        s_frac = sv[57] ? -$signed({2'b00, vm[15:0]}) : $signed({2'b00, vm[15:0]});
    end

    always_comb
    begin
        lat_x    = xi_reg + 32'(cmd.pt[1:0]) - 32'd1;
        lat_y    = yi_reg + 32'(cmd.pt[3:2]) - 32'd1;
        n0       = lat_x + lat_y * smvn_pkg::HASH_YMUL;
        hn       = (n0 << 13) ^ n0;
        poly     = prod_reg[31:0] * smvn_pkg::HASH_C2 + smvn_pkg::HASH_C3;
        t_hash   = (prod_reg[31:0] + smvn_pkg::HASH_C4) & smvn_pkg::HASH_MASK;
        lval     = $signed(smvn_pkg::LAT_ONE) - $signed(t_hash);
        lval_ext = CRN_W'(lval);
        add00    = corner_add(cmd.pt, 1'b0, 1'b0, lval_ext);
        add10    = corner_add(cmd.pt, 1'b1, 1'b0, lval_ext);
        add01    = corner_add(cmd.pt, 1'b0, 1'b1, lval_ext);
        add11    = corner_add(cmd.pt, 1'b1, 1'b1, lval_ext);
    end

    always_comb
    begin
        case (cmd.sel)
            2'd0:    crv_a = 19'(xf_reg);
            2'd1:    crv_a = 19'sd65536 - 19'(xf_reg);
            2'd2:    crv_a = 19'(yf_reg);
            default: crv_a = 19'sd65536 - 19'(yf_reg);
        endcase
        fac = 21'sd196608 - (21'(crv_a) <<< 1);
        case (cmd.sel)
            2'd0:
            begin
                bl_p  = c00_reg;
                bl_q  = c10_reg;
                bl_w0 = wx0_reg;
                bl_w1 = wx1_reg;
            end
            2'd1:
            begin
                bl_p  = c01_reg;
                bl_q  = c11_reg;
                bl_w0 = wx0_reg;
                bl_w1 = wx1_reg;
            end
            default:
            begin
                bl_p  = v1_reg;
                bl_q  = v2_reg;
                bl_w0 = wy0_reg;
                bl_w1 = wy1_reg;
            end
        endcase
        bsum = acc_reg + prod_reg[ACC_W-1:0];
    end

    always_comb
    begin
        sneg = sum_reg[SUM_W-1];
        mag  = sneg ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        hi   = prod_reg[34:0];
        q    = 42'({hi[15:0], 16'b0}) + 42'(lo_reg[55:16]);
        if (sneg)
        begin
            if (hi >= 35'd65536 || q > 42'h0_8000_0000)
            begin
                h_next = 32'sh8000_0000;
            end
            else
            begin
                h_next = -$signed(q[31:0]);
            end
        end
        else
        begin
            if (hi >= 35'd65536 || q > 42'h0_7fff_ffff)
            begin
                h_next = 32'sh7fff_ffff;
            end
            else
            begin
                h_next = $signed(q[31:0]);
            end
        end
    end

    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (cmd.op)
            smvn_pkg::OP_MUL_SX:
            begin
                mul_a = MA_W'(cy_reg);
                mul_b = MB_W'({1'b0, base_frequency});
            end
            smvn_pkg::OP_SCALE_X:
            begin
                mul_a = MA_W'(cx_reg);
                mul_b = MB_W'({1'b0, base_frequency});
            end
            smvn_pkg::OP_HASH_SQ:
            begin
                mul_a = MA_W'({1'b0, hn});
                mul_b = MB_W'({1'b0, hn});
            end
            smvn_pkg::OP_HASH_MUL:
            begin
                mul_a = MA_W'({1'b0, m_reg});
                mul_b = MB_W'({1'b0, n_reg});
            end
            smvn_pkg::OP_CURVE_SQ:
            begin
                mul_a = MA_W'(crv_a);
                mul_b = MB_W'(crv_a);
            end
            smvn_pkg::OP_CURVE_CUBE:
            begin
                mul_a = prod_reg[MA_W-1:0];
                mul_b = MB_W'(fac);
            end
            smvn_pkg::OP_BLEND_0:
            begin
                mul_a = bl_p;
                mul_b = MB_W'(bl_w0);
            end
            smvn_pkg::OP_BLEND_1:
            begin
                mul_a = bl_q;
                mul_b = MB_W'(bl_w1);
            end
            smvn_pkg::OP_TERM:
            begin
                mul_a = MA_W'(val_reg);
                mul_b = MB_W'({1'b0, amp_reg});
            end
            smvn_pkg::OP_SUM_AMP:
            begin
                mul_a = MA_W'({1'b0, amp_reg});
                mul_b = MB_W'({1'b0, persistence});
            end
            smvn_pkg::OP_FIN_LO:
            begin
                mul_a = MA_W'({1'b0, mag[31:0]});
                mul_b = MB_W'({1'b0, output_gain});
            end
            smvn_pkg::OP_FIN_HI:
            begin
                mul_a = MA_W'({1'b0, mag[42:32]});
                mul_b = MB_W'({1'b0, output_gain});
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (capture)
        begin
            cx_reg  <= coord_x;
            cy_reg  <= coord_y;
            sum_reg <= '0;
            amp_reg <= smvn_pkg::AMP_ONE;
        end
        case (cmd.op)
            smvn_pkg::OP_SCALE_X:
            begin
                xi_reg <= s_int;
                xf_reg <= s_frac;
            end
            smvn_pkg::OP_SCALE_Y:
            begin
                yi_reg  <= s_int;
                yf_reg  <= s_frac;
                c00_reg <= '0;
                c10_reg <= '0;
                c01_reg <= '0;
                c11_reg <= '0;
            end
            smvn_pkg::OP_HASH_SQ:
            begin
                n_reg <= hn;
            end
            smvn_pkg::OP_HASH_POLY:
            begin
                m_reg <= poly;
            end
            smvn_pkg::OP_HASH_ACC:
            begin
                c00_reg <= c00_reg + add00;
                c10_reg <= c10_reg + add10;
                c01_reg <= c01_reg + add01;
                c11_reg <= c11_reg + add11;
            end
            smvn_pkg::OP_CURVE_STORE:
            begin
                case (cmd.sel)
                    2'd0:    wx1_reg <= prod_reg[52:24];
                    2'd1:    wx0_reg <= prod_reg[52:24];
                    2'd2:    wy1_reg <= prod_reg[52:24];
                    default: wy0_reg <= prod_reg[52:24];
                endcase
            end
            smvn_pkg::OP_BLEND_1:
            begin
                acc_reg <= prod_reg[ACC_W-1:0];
            end
            smvn_pkg::OP_BLEND_2:
            begin
                case (cmd.sel)
                    2'd0:    v1_reg  <= bsum[63:28];
                    2'd1:    v2_reg  <= bsum[63:28];
                    default: val_reg <= bsum[61:38];
                endcase
            end
            smvn_pkg::OP_SUM_AMP:
            begin
                sum_reg <= sum_reg + prod_reg[59:16];
            end
            smvn_pkg::OP_AMP:
            begin
                amp_reg <= prod_reg[47:16];
            end
            smvn_pkg::OP_FIN_HI:
            begin
                lo_reg <= prod_reg[55:0];
            end
            smvn_pkg::OP_FIN_OUT:
            begin
                height_reg <= h_next;
            end
            default:
            begin
            end
        endcase
    end

    assign height = height_reg;

endmodule

// ===== hw/rtl/smoothed_value_noise_octaves.sv =====
// Top level of the smoothed value noise block: configuration registers, sequencer, datapath.
// Depends on smvn_pkg, smvn_ctrl and smvn_datapath.
// A point is taken when start is high and busy is low; busy then stays high until the
// height comes out, and done marks the single cycle in which height holds the result,
// with no way for the receiver to stall it. One shared 36x33 multiplier does all the
// work, so each octave runs in order through coordinate scaling, the sixteen lattice
// hashes, the four blend curves, the three blends and the octave term and amplitude
// update, and the output gain is applied last. With zero octaves only the output gain
// step runs. A new point may be started in the done cycle. Configuration writes
// are always ready and take effect at once.
module smoothed_value_noise_octaves #(
    parameter int MAX_OCTAVES = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    output logic                                 done,
    input  logic signed [31:0]                   coord_x,
    input  logic signed [31:0]                   coord_y,
    output logic signed [31:0]                   height,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [smvn_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [smvn_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [16:0]        persistence_reg;
    logic [23:0]        base_frequency_reg;
    logic [23:0]        output_gain_reg;
    logic [3:0]         octave_count_reg;
    logic [30:0]        seed_offset_reg;
    logic               accept;
    smvn_pkg::cmd_t     cmd;

    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            persistence_reg    <= '0;
            base_frequency_reg <= '0;
            output_gain_reg    <= '0;
            octave_count_reg   <= '0;
            seed_offset_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                smvn_pkg::CFG_PERSISTENCE: persistence_reg    <= cfg_data[16:0];
                smvn_pkg::CFG_BASE_FREQ:   base_frequency_reg <= cfg_data[23:0];
                smvn_pkg::CFG_OUTPUT_GAIN: output_gain_reg    <= cfg_data[23:0];
                smvn_pkg::CFG_OCT_COUNT:   octave_count_reg   <= cfg_data[3:0];
                smvn_pkg::CFG_SEED_OFFSET: seed_offset_reg    <= cfg_data[30:0];
                default:
                begin
                end
            endcase
        end
    end

    smvn_ctrl #(
        .MAX_OCTAVES (MAX_OCTAVES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (accept),
        .octave_count (octave_count_reg),
        .busy         (busy),
        .done         (done),
        .cmd          (cmd)
    );

    smvn_datapath u_datapath (
        .clk            (clk),
        .cmd            (cmd),
        .capture        (accept),
        .coord_x        (coord_x),
        .coord_y        (coord_y),
        .persistence    (persistence_reg),
        .base_frequency (base_frequency_reg),
        .output_gain    (output_gain_reg),
        .seed_offset    (seed_offset_reg),
        .height         (height)
    );

endmodule

// ===== hw/rtl/smvn_checker.sv =====
// Port-level checks of the smoothed value noise block, bound to the top level.
// Depends on smoothed_value_noise_octaves_assert.svh.
`include "smoothed_value_noise_octaves_assert.svh"

module smvn_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    `SMVN_ASSERT_NEXT(a_accept_sets_busy, clk, rst_n, start && !busy, busy)
    `SMVN_ASSERT_NOW(a_done_frees, clk, rst_n, done, !busy)
    `SMVN_ASSERT_NEXT(a_done_one_beat, clk, rst_n, done, !done)
    `SMVN_ASSERT_NOW(a_done_after_work, clk, rst_n, done, $past(busy))

endmodule

bind smoothed_value_noise_octaves smvn_checker u_smvn_checker (.*);

// ===== tb/smvn_noise_checker.sv =====
// Checker of the smoothed value noise block: tracks register writes, predicts each height.
// Compares every done beat against the oldest prediction; depends on smvn_pkg.
module smvn_noise_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic                                 done,
    input  logic signed [31:0]                   coord_x,
    input  logic signed [31:0]                   coord_y,
    input  logic signed [31:0]                   height,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [smvn_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [smvn_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                   error_count,
    output int                                   pending
);

    bit [16:0] persist_q;
    bit [23:0] freq_q;
    bit [23:0] gain_q;
    bit [3:0]  octaves_q;
    bit [30:0] seed_q;

    logic signed [31:0] height_queue[$];

    function automatic longint lattice_value(bit [31:0] xi, bit [31:0] yi);
        bit [31:0] n;
        bit [31:0] t;
        n = xi + yi * smvn_pkg::HASH_YMUL;
        n = (n << 13) ^ n;
        t = (n * (n * n * smvn_pkg::HASH_C2 + smvn_pkg::HASH_C3) + smvn_pkg::HASH_C4)
          & smvn_pkg::HASH_MASK;
        return longint'(smvn_pkg::LAT_ONE) - longint'(t);
    endfunction

    function automatic longint smooth_corner(bit [31:0] cx, bit [31:0] cy);
        longint diag;
        longint side;
        diag = lattice_value(cx - 1, cy - 1) + lattice_value(cx + 1, cy - 1)
             + lattice_value(cx - 1, cy + 1) + lattice_value(cx + 1, cy + 1);
        side = lattice_value(cx - 1, cy) + lattice_value(cx + 1, cy)
             + lattice_value(cx, cy - 1) + lattice_value(cx, cy + 1);
        return diag + 2 * side + 4 * lattice_value(cx, cy);
    endfunction

    function automatic longint fade(longint a);
        longint sq;
        sq = a * a;
        return (3 * sq * 65536 - 2 * sq * a) >>> 24;
    endfunction

    function automatic longint mix(longint p, longint q, longint a, int s);
        return (p * fade(65536 - a) + q * fade(a)) >>> s;
    endfunction

    function automatic void scale_coord(logic signed [31:0] c, int k,
                                        output bit [31:0] ip, output longint fp);
        longint prod;
        longint mag;
        longint v;
        longint ipl;
        prod = longint'(c) * longint'(freq_q);
        mag  = (prod < 0) ? -prod : prod;
        mag  = mag >>> (16 - k);
        v    = (prod < 0) ? -mag : mag;
        v    = v + longint'(seed_q) * 65536;
        ipl  = (v >= 0) ? (v >>> 16) : -((-v) >>> 16);
        fp   = v - ipl * 65536;
        ip   = ipl[31:0];
    endfunction

    function automatic longint octave_value(logic signed [31:0] cx,
                                            logic signed [31:0] cy, int k);
        bit [31:0] xi;
        bit [31:0] yi;
        longint xf;
        longint yf;
        longint v1;
        longint v2;
        scale_coord(cy, k, xi, xf);
        scale_coord(cx, k, yi, yf);
        v1 = mix(smooth_corner(xi, yi), smooth_corner(xi + 1, yi), xf, 28);
        v2 = mix(smooth_corner(xi, yi + 1), smooth_corner(xi + 1, yi + 1), xf, 28);
        return mix(v1, v2, yf, 38);
    endfunction

    function automatic logic signed [31:0] noise_height(logic signed [31:0] cx,
                                                        logic signed [31:0] cy);
        int        count;
        longint    amp;
        longint    sum;
        bit [63:0] mag;
        bit [63:0] lo;
        bit [63:0] hi;
        bit [63:0] q;
        count = (octaves_q > 8) ? 8 : int'(octaves_q);
        amp   = 65536;
        sum   = 0;
        for (int k = 0; k < count; k++)
        begin
            sum = sum + ((octave_value(cx, cy, k) * amp) >>> 16);
            amp = (amp * longint'(persist_q)) >>> 16;
        end
        mag = (sum < 0) ? -sum : sum;
        lo  = (mag & 64'hffff_ffff) * gain_q;
        hi  = (mag >> 32) * gain_q;
        q   = (hi >= 65536) ? 64'h1_0000_0000 : (hi << 16) + (lo >> 16);
        if (sum < 0)
            return (q > 64'h8000_0000) ? 32'h8000_0000 : -q[31:0];
        return (q > 64'h7fff_ffff) ? 32'h7fff_ffff : q[31:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [31:0] want;
        if (!rst_n)
        begin
            persist_q   <= '0;
            freq_q      <= '0;
            gain_q      <= '0;
            octaves_q   <= '0;
            seed_q      <= '0;
            error_count <= 0;
            pending     <= 0;
            height_queue.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    smvn_pkg::CFG_PERSISTENCE: persist_q <= cfg_data[16:0];
                    smvn_pkg::CFG_BASE_FREQ:   freq_q    <= cfg_data[23:0];
                    smvn_pkg::CFG_OUTPUT_GAIN: gain_q    <= cfg_data[23:0];
                    smvn_pkg::CFG_OCT_COUNT:   octaves_q <= cfg_data[3:0];
                    smvn_pkg::CFG_SEED_OFFSET: seed_q    <= cfg_data[30:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                height_queue.push_back(noise_height(coord_x, coord_y));
            if (done)
            begin
                if (height_queue.size() == 0)
                begin
                    $error("height: unexpected beat, got %0d", height);
                    error_count <= error_count + 1;
                end
                else
                begin
                    want = height_queue.pop_front();
                    if (height !== want)
                    begin
                        $error("height: expected %0d, got %0d", want, height);
                        error_count <= error_count + 1;
                    end
                end
            end
            pending <= height_queue.size();
        end
    end

endmodule

// ===== tb/smoothed_value_noise_octaves_tb.sv =====
// Top of the noise block testbench: clock, reset, register phases and point stimulus.
// Depends on smvn_pkg, smoothed_value_noise_octaves and smvn_noise_checker.
module smoothed_value_noise_octaves_tb;

    localparam int CFG_IDX_W  = smvn_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = smvn_pkg::CFG_DATA_W;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  done;
    logic signed [31:0]    coord_x;
    logic signed [31:0]    coord_y;
    logic signed [31:0]    height;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    error_count;
    int                    pending;

    smoothed_value_noise_octaves #(
        .MAX_OCTAVES (8)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .done      (done),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .height    (height),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    smvn_noise_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .done        (done),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .height      (height),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .error_count (error_count),
        .pending     (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic write_setup(logic [16:0] persist, logic [23:0] freq, logic [23:0] gain,
                               logic [3:0] octaves, logic [30:0] seed);
        write_reg(smvn_pkg::CFG_PERSISTENCE, CFG_DATA_W'(persist));
        write_reg(smvn_pkg::CFG_BASE_FREQ, CFG_DATA_W'(freq));
        write_reg(smvn_pkg::CFG_OUTPUT_GAIN, CFG_DATA_W'(gain));
        write_reg(smvn_pkg::CFG_OCT_COUNT, CFG_DATA_W'(octaves));
        write_reg(smvn_pkg::CFG_SEED_OFFSET, CFG_DATA_W'(seed));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_point(logic signed [31:0] x, logic signed [31:0] y);
        int gap;
        gap = $urandom_range(0, 14);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        coord_x <= x;
        coord_y <= y;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic drain;
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0 || busy);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_edges;
        send_point(32'sd0, 32'sd0);
        send_point(32'sh7fff_ffff, 32'sh7fff_ffff);
        send_point(32'sh8000_0000, 32'sh8000_0000);
        send_point(-32'sd1, 32'sd1);
        send_point(32'sh7fff_ffff, 32'sh8000_0000);
        send_point(32'sh0000_8000, -32'sh0000_8000);
        send_point(32'sh0001_0000, -32'sh0001_0000);
    endtask

    function automatic logic [16:0] pick_persist();
        case ($urandom_range(0, 4))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'h1ffff;
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [23:0] pick_q8(int hint);
        case (hint)
            0: return 24'd0;
            1: return 24'hff_ffff;
            2: return 24'($urandom_range(0, 24'h03_ffff));
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic logic signed [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 32'($urandom_range(0, 32'h000f_ffff));
            1: return -32'($urandom_range(0, 32'h000f_ffff));
            2: return {{16{1'b1}}, 16'($urandom())};
            default: return 32'($urandom());
        endcase
    endfunction

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        coord_x   = '0;
        coord_y   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_point(32'sh0001_8000, -32'sh0002_4000);
        send_point(32'sh7fff_ffff, 32'sh8000_0000);
        drain();

        write_setup(17'd32768, 24'h01_0000, 24'h01_0000, 4'd4, 31'd2);
        write_reg(3'd5, '1);
        write_reg(3'd7, '0);
        cfg_valid <= 1'b0;
        send_edges();
        drain();

        write_setup(17'h1ffff, 24'hff_ffff, 24'hff_ffff, 4'd15, 31'h7fff_ffff);
        send_edges();
        drain();

        write_setup(17'd65536, 24'h00_0001, 24'h00_0000, 4'd0, 31'd0);
        send_point(32'sh1234_5678, -32'sh0765_4321);
        send_point(-32'sd1, -32'sd1);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            write_setup(pick_persist(), pick_q8($urandom_range(0, 4)),
                        pick_q8($urandom_range(1, 4)), 4'($urandom_range(0, 15)),
                        (phase == 3) ? 31'h7fff_ffff : 31'($urandom_range(0, 1000)));
            for (int n = 0; n < 72; n++)
                send_point(pick_coord(), pick_coord());
            drain();
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/smvn_pkg.sv
hw/rtl/smvn_ctrl.sv
hw/rtl/smvn_datapath.sv
hw/rtl/smoothed_value_noise_octaves.sv
hw/rtl/smvn_checker.sv
tb/smvn_noise_checker.sv
tb/smoothed_value_noise_octaves_tb.sv
